FILE: rtl/sync_frame_receiver_crc16_assert.svh
// Assertion macros used by the frame receiver datapath.
`ifndef SYNC_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Check that cons holds in every cycle in which ante holds, outside reset.
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr implication check failed");

// Check that cond never holds outside reset.
`define SFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sfr forbidden condition seen");

`endif

FILE: rtl/sfr_pkg.sv
// Shared types, constants and the CRC-16 step function of the frame receiver.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 5;
    localparam int COUNT_W    = 32;
    localparam int CRC_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] NODE_ADDR_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] BCAST_ADDR_RST = 8'd255;
    localparam logic [BYTE_W-1:0] SYNC_VALUE_RST = 8'd126;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDR  = 2'd0,
        CFG_BCAST_ADDR = 2'd1,
        CFG_SYNC_VALUE = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_CRC  = 2'd2,
        ST_NOT_ADDR = 2'd3
    } t_status;

    // Kind of result the datapath loads into its output register.
    typedef enum logic [2:0] {
        K_BAD_LEN  = 3'd0,
        K_BAD_CRC  = 3'd1,
        K_NOT_ADDR = 3'd2,
        K_EMPTY    = 3'd3,
        K_PAYLOAD  = 3'd4
    } t_res_kind;

    typedef struct packed {
        logic      crc_init;
        logic      crc_upd;
        logic      ld_addr;
        logic      ld_len;
        logic      ld_data;
        logic      ld_crc_lo;
        logic      err_inc;
        logic      frm_inc;
        logic      out_ld;
        t_res_kind out_kind;
        logic      run_start;
        logic      run_adv;
    } t_cmd;

    typedef struct packed {
        logic sync_hit;
        logic len_over;
        logic rx_zero;
        logic len_zero;
        logic data_done;
        logic crc_ok;
        logic addr_ok;
        logic run_last;
        logic out_free;
    } t_sts;

    // One byte through the reflected CRC-16, eight shift steps.
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sfr_rx_if.sv
// Byte input channel of the frame receiver.
`default_nettype none

interface sfr_rx_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_res_if.sv
// Result channel of the frame receiver.
`default_nettype none

interface sfr_res_if;
    logic                         valid;
    logic                         ready;
    logic [sfr_pkg::STATUS_W-1:0] status;
    logic [sfr_pkg::BYTE_W-1:0]   payload_byte;
    logic [sfr_pkg::LEN_W-1:0]    payload_length;
    logic                         is_broadcast;
    logic                         last;
    logic [sfr_pkg::COUNT_W-1:0]  error_count;
    logic [sfr_pkg::COUNT_W-1:0]  frame_count;

    modport source (output valid, output status, output payload_byte,
                    output payload_length, output is_broadcast, output last,
                    output error_count, output frame_count, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input payload_length, input is_broadcast, input last,
                    input error_count, input frame_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_ctrl.sv
// Frame phase state machine: issues datapath commands per accepted byte and per payload byte of a run.
`default_nettype none

module sfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire sfr_pkg::t_sts i_sts,
    output sfr_pkg::t_cmd      o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT,
        S_ADDR,
        S_LEN,
        S_DATA,
        S_CRC_LO,
        S_CRC_HI,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    // Hold off new bytes during a payload run and while the result slot is full.
    assign o_rx_ready = (r_state != S_EMIT) && i_sts.out_free;
    assign acc        = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_kind = K_PAYLOAD;
        unique case (r_state)
            S_HUNT: begin
                if (acc && i_sts.sync_hit) begin
                    o_cmd.crc_init = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: begin
                if (acc) begin
                    o_cmd.ld_addr = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    n_state       = S_LEN;
                end
            end
            S_LEN: begin
                if (acc) begin
                    o_cmd.ld_len  = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    if (i_sts.len_over) begin
                        o_cmd.err_inc  = 1'b1;
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = K_BAD_LEN;
                        n_state        = S_HUNT;
                    end else if (i_sts.rx_zero) begin
                        n_state = S_CRC_LO;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (acc) begin
                    o_cmd.ld_data = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    if (i_sts.data_done) begin
                        n_state = S_CRC_LO;
                    end
                end
            end
            S_CRC_LO: begin
                if (acc) begin
                    o_cmd.ld_crc_lo = 1'b1;
                    n_state         = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (acc) begin
                    n_state = S_HUNT;
                    if (!i_sts.crc_ok) begin
                        o_cmd.err_inc  = 1'b1;
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = K_BAD_CRC;
                    end else if (!i_sts.addr_ok) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = K_NOT_ADDR;
                    end else if (i_sts.len_zero) begin
                        o_cmd.frm_inc  = 1'b1;
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = K_EMPTY;
                    end else begin
                        o_cmd.frm_inc   = 1'b1;
                        o_cmd.run_start = 1'b1;
                        n_state         = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = K_PAYLOAD;
                    o_cmd.run_adv  = 1'b1;
                    if (i_sts.run_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfr_dpath.sv
// Frame receiver datapath: config, CRC, payload store, counters, result register.
`default_nettype none
`include "sync_frame_receiver_crc16_assert.svh"

module sfr_dpath #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      i_cfg_data,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      i_rx_byte,
    input  wire sfr_pkg::t_cmd                   i_cmd,
    output sfr_pkg::t_sts                        o_sts,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output sfr_pkg::t_status                     o_status,
    output logic [sfr_pkg::BYTE_W-1:0]           o_payload_byte,
    output logic [sfr_pkg::LEN_W-1:0]            o_payload_length,
    output logic                                 o_is_broadcast,
    output logic                                 o_last,
    output logic [sfr_pkg::COUNT_W-1:0]          o_error_count,
    output logic [sfr_pkg::COUNT_W-1:0]          o_frame_count
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0]  r_node_addr;
    logic [BYTE_W-1:0]  r_bcast_addr;
    logic [BYTE_W-1:0]  r_sync_value;
    logic [BYTE_W-1:0]  r_frame_addr;
    logic [CNT_W-1:0]   r_frame_len;
    logic [CNT_W-1:0]   r_byte_idx;
    logic [CNT_W-1:0]   r_run_idx;
    logic [CRC_W-1:0]   r_crc;
    logic [CRC_W-1:0]   n_crc;
    logic [BYTE_W-1:0]  r_crc_lo;
    logic [BYTE_W-1:0]  r_store [MAX_PAYLOAD];
    logic [COUNT_W-1:0] r_err_cnt;
    logic [COUNT_W-1:0] r_frm_cnt;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_bc;
    logic               r_out_last;
    logic               is_bcast;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr  <= NODE_ADDR_RST;
            r_bcast_addr <= BCAST_ADDR_RST;
            r_sync_value <= SYNC_VALUE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_ADDR:  r_node_addr  <= i_cfg_data;
                CFG_BCAST_ADDR: r_bcast_addr <= i_cfg_data;
                CFG_SYNC_VALUE: r_sync_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_crc = crc16_update(r_crc, i_rx_byte);

    // Frame fields, CRC and indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_addr <= '0;
            r_frame_len  <= '0;
            r_byte_idx   <= '0;
            r_run_idx    <= '0;
            r_crc        <= CRC_INIT;
            r_crc_lo     <= '0;
        end else begin
            if (i_cmd.crc_init) begin
                r_crc <= CRC_INIT;
            end else if (i_cmd.crc_upd) begin
                r_crc <= n_crc;
            end
            if (i_cmd.ld_addr) begin
                r_frame_addr <= i_rx_byte;
            end
            if (i_cmd.ld_len) begin
                r_frame_len <= i_rx_byte[CNT_W-1:0];
                r_byte_idx  <= '0;
            end else if (i_cmd.ld_data) begin
                r_byte_idx <= r_byte_idx + CNT_W'(1);
            end
            if (i_cmd.ld_crc_lo) begin
                r_crc_lo <= i_rx_byte;
            end
            if (i_cmd.run_start) begin
                r_run_idx <= '0;
            end else if (i_cmd.run_adv) begin
                r_run_idx <= r_run_idx + CNT_W'(1);
            end
        end
    end

    // Payload store, no reset: only entries of the current frame are read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_data) begin
            r_store[r_byte_idx[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_cnt <= '0;
            r_frm_cnt <= '0;
        end else begin
            if (i_cmd.err_inc) begin
                r_err_cnt <= r_err_cnt + COUNT_W'(1);
            end
            if (i_cmd.frm_inc) begin
                r_frm_cnt <= r_frm_cnt + COUNT_W'(1);
            end
        end
    end

    assign is_bcast = (r_frame_addr == r_bcast_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            case (i_cmd.out_kind) inside
                K_BAD_LEN, K_BAD_CRC: begin
                    r_out_status <= (i_cmd.out_kind == K_BAD_LEN) ? ST_BAD_LEN : ST_BAD_CRC;
                    r_out_byte   <= '0;
                    r_out_len    <= '0;
                    r_out_bc     <= 1'b0;
                    r_out_last   <= 1'b1;
                end
                K_NOT_ADDR: begin
                    r_out_status <= ST_NOT_ADDR;
                    r_out_byte   <= '0;
                    r_out_len    <= LEN_W'(r_frame_len);
                    r_out_bc     <= 1'b0;
                    r_out_last   <= 1'b1;
                end
                K_EMPTY: begin
                    r_out_status <= ST_ACCEPTED;
                    r_out_byte   <= '0;
                    r_out_len    <= '0;
                    r_out_bc     <= is_bcast;
                    r_out_last   <= 1'b1;
                end
                default: begin
                    r_out_status <= ST_ACCEPTED;
                    r_out_byte   <= r_store[r_run_idx[IDX_W-1:0]];
                    r_out_len    <= LEN_W'(r_frame_len);
                    r_out_bc     <= is_bcast;
                    r_out_last   <= o_sts.run_last;
                end
            endcase
        end
    end

    // Status toward the controller
    assign o_sts.sync_hit  = (i_rx_byte == r_sync_value);
    assign o_sts.len_over  = (i_rx_byte > BYTE_W'(MAX_PAYLOAD));
    assign o_sts.rx_zero   = (i_rx_byte == '0);
    assign o_sts.len_zero  = (r_frame_len == '0);
    assign o_sts.data_done = ((r_byte_idx + CNT_W'(1)) >= r_frame_len);
    assign o_sts.crc_ok    = ({i_rx_byte, r_crc_lo} == r_crc);
    assign o_sts.addr_ok   = (r_frame_addr == r_node_addr) || is_bcast;
    assign o_sts.run_last  = ((r_run_idx + CNT_W'(1)) == r_frame_len);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_payload_byte   = r_out_byte;
    assign o_payload_length = r_out_len;
    assign o_is_broadcast   = r_out_bc;
    assign o_last           = r_out_last;
    assign o_error_count    = r_err_cnt;
    assign o_frame_count    = r_frm_cnt;

    `SFR_ASSERT_IMPL(a_load_slot_free, i_clk, i_rst_n, i_cmd.out_ld, o_sts.out_free)
    `SFR_ASSERT_IMPL(a_run_in_range, i_clk, i_rst_n, i_cmd.run_adv, r_run_idx < r_frame_len)
    `SFR_ASSERT_IMPL(a_accept_checked, i_clk, i_rst_n, i_cmd.frm_inc, o_sts.crc_ok && o_sts.addr_ok)
    `SFR_ASSERT_NEVER(a_err_xor_frame, i_clk, i_rst_n, i_cmd.err_inc && i_cmd.frm_inc)

endmodule

`default_nettype wire

FILE: rtl/sync_frame_receiver_crc16.sv
// A status result is registered and valid in the cycle after the closing byte; a payload
// run starts from the emit state and delivers one byte per cycle while the result slot is free.
// Input takes 1 byte per cycle while framing and the result slot is free; a payload run
// holds the input until its last byte enters the single result register that the run shares.
// Reset (i_rst_n low, synchronous): hunt for sync, counters cleared, config at
// defaults (node 0, broadcast 255, sync 126); payload store is not cleared.
`default_nettype none

module sync_frame_receiver_crc16 #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sfr_pkg::BYTE_W-1:0]    i_cfg_data,
    sfr_rx_if.sink                             i_rx,
    sfr_res_if.source                          o_res
);
    import sfr_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_status res_status;

    // Controller: tracks sync, address, length, payload and CRC phases and
    // sequences the payload run once a frame checks out.
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: holds config, frame fields, running CRC, payload bytes,
    // counters and the result register that decouples the two channels.
    sfr_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx.rx_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_status         (res_status),
        .o_payload_byte   (o_res.payload_byte),
        .o_payload_length (o_res.payload_length),
        .o_is_broadcast   (o_res.is_broadcast),
        .o_last           (o_res.last),
        .o_error_count    (o_res.error_count),
        .o_frame_count    (o_res.frame_count)
    );

    // Counters change only when a frame closes, and a frame closes only when
    // the result slot is free, so they read correctly with every transfer.
    assign o_res.status = res_status;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the sync/length CRC-16 frame receiver.
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int MAX_LEN = 16;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_R = 16'hA001;

    // Where the receiver model stands within a frame.
    typedef enum logic [2:0] {
        HUNT,
        GET_ADDR,
        GET_LEN,
        GET_DATA,
        GET_CRC_LO,
        GET_CRC_HI
    } t_rx_phase;

    typedef struct {
        t_status      status;
        logic [7:0]   payload_byte;
        logic [4:0]   payload_length;
        logic         is_broadcast;
        logic         last;
        logic [31:0]  error_count;
        logic [31:0]  frame_count;
    } t_rx_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_idx   i_cfg_idx;
    logic [7:0] i_cfg_data;

    sfr_rx_if  rx_ch ();
    sfr_res_if res_ch ();

    sync_frame_receiver_crc16 #(
        .MAX_PAYLOAD(MAX_LEN)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_rx      (rx_ch),
        .o_res     (res_ch)
    );

    // Bytes waiting to go out and results the receiver still owes us.
    logic [7:0] tx_bytes[$];
    t_rx_result due_results[$];

    // Shadow copy of the configuration registers.
    logic [7:0] cfg_node;
    logic [7:0] cfg_bcast;
    logic [7:0] cfg_sync;

    // Shadow copy of the framing state.
    t_rx_phase   fr_phase;
    logic [7:0]  fr_addr;
    logic [7:0]  fr_len;
    logic [4:0]  fr_count;
    logic [15:0] fr_crc;
    logic [7:0]  fr_crc_lo;
    logic [7:0]  fr_payload[MAX_LEN];
    logic [31:0] err_total;
    logic [31:0] frame_total;

    int mismatch_count;
    int stim_items;
    int send_gap;
    bit send_busy;
    int stall_left;
    bit stall_busy;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reflected CRC-16, one input bit per shift.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
        end
        return c;
    endfunction

    // Idle length: none in quiet stretches, otherwise mostly short with a few long ones.
    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic expect_result(input t_status st, input logic [7:0] pb,
                                 input logic [4:0] len, input logic bc, input logic lst);
        t_rx_result r;
        r.status         = st;
        r.payload_byte   = pb;
        r.payload_length = len;
        r.is_broadcast   = bc;
        r.last           = lst;
        r.error_count    = err_total;
        r.frame_count    = frame_total;
        due_results.push_back(r);
    endtask

    // Advance the framing state by one received byte and queue what it produces.
    task automatic decode_rx_byte(input logic [7:0] b);
        logic [15:0] got_crc;
        logic        bc;
        case (fr_phase)
            HUNT: begin
                // anything but the sync byte is dropped while hunting
                if (b == cfg_sync) begin
                    fr_phase = GET_ADDR;
                    fr_count = '0;
                    fr_crc   = CRC_SEED;
                end
            end
            GET_ADDR: begin
                fr_addr  = b;
                fr_crc   = crc_byte(fr_crc, b);
                fr_phase = GET_LEN;
            end
            GET_LEN: begin
                fr_len = b;
                fr_crc = crc_byte(fr_crc, b);
                if (b > MAX_LEN) begin
                    err_total++;
                    fr_phase = HUNT;
                    expect_result(ST_BAD_LEN, 8'd0, 5'd0, 1'b0, 1'b1);
                end else begin
                    fr_count = '0;
                    fr_phase = (b == 8'd0) ? GET_CRC_LO : GET_DATA;
                end
            end
            GET_DATA: begin
                fr_payload[fr_count[3:0]] = b;
                fr_crc   = crc_byte(fr_crc, b);
                fr_count = fr_count + 5'd1;
                if (fr_count >= fr_len) fr_phase = GET_CRC_LO;
            end
            GET_CRC_LO: begin
                fr_crc_lo = b;
                fr_phase  = GET_CRC_HI;
            end
            default: begin
                // high CRC byte closes the frame: CRC first, then address
                got_crc  = {b, fr_crc_lo};
                fr_phase = HUNT;
                if (got_crc != fr_crc) begin
                    err_total++;
                    expect_result(ST_BAD_CRC, 8'd0, 5'd0, 1'b0, 1'b1);
                end else if (fr_addr != cfg_node && fr_addr != cfg_bcast) begin
                    expect_result(ST_NOT_ADDR, 8'd0, fr_len[4:0], 1'b0, 1'b1);
                end else begin
                    frame_total++;
                    bc = (fr_addr == cfg_bcast);
                    if (fr_len == 8'd0) begin
                        expect_result(ST_ACCEPTED, 8'd0, 5'd0, bc, 1'b1);
                    end else begin
                        for (int i = 0; i < fr_len; i++) begin
                            expect_result(ST_ACCEPTED, fr_payload[i], fr_len[4:0], bc,
                                          i + 1 == fr_len);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_rx_result want;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected result status", 32'(res_ch.status), 32'd0);
            return;
        end
        want = due_results.pop_front();
        if (res_ch.status !== want.status)
            report_mismatch("status", 32'(res_ch.status), 32'(want.status));
        if (res_ch.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(res_ch.payload_byte), 32'(want.payload_byte));
        if (res_ch.payload_length !== want.payload_length)
            report_mismatch("payload_length", 32'(res_ch.payload_length),
                            32'(want.payload_length));
        if (res_ch.is_broadcast !== want.is_broadcast)
            report_mismatch("is_broadcast", 32'(res_ch.is_broadcast), 32'(want.is_broadcast));
        if (res_ch.last !== want.last)
            report_mismatch("last", 32'(res_ch.last), 32'(want.last));
        if (res_ch.error_count !== want.error_count)
            report_mismatch("error_count", res_ch.error_count, want.error_count);
        if (res_ch.frame_count !== want.frame_count)
            report_mismatch("frame_count", res_ch.frame_count, want.frame_count);
    endtask

    // Driver: predict on every transfer, then present the next byte after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                decode_rx_byte(rx_ch.rx_byte);
                if ($urandom_range(0, 49) == 0) send_busy = ~send_busy;
            end
            if (rx_ch.valid && !rx_ch.ready) begin
                // hold the byte until the receiver takes it
            end else if (send_gap > 0) begin
                send_gap--;
                rx_ch.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= tx_bytes.pop_front();
                send_gap = pick_gap(send_busy);
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every result transfer and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_result();
                if ($urandom_range(0, 49) == 0) stall_busy = ~stall_busy;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left = pick_gap(stall_busy);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit counted);
        tx_bytes.push_back(b);
        if (counted) stim_items++;
    endtask

    // Queue one whole frame; optionally corrupt the CRC or put the sync byte
    // at the head of the payload.
    task automatic add_frame(input logic [7:0] addr, input int len, input bit crc_good,
                             input bit sync_first);
        logic [7:0]  data[MAX_LEN];
        logic [15:0] crc;
        crc = CRC_SEED;
        crc = crc_byte(crc, addr);
        crc = crc_byte(crc, 8'(len));
        for (int i = 0; i < len; i++) begin
            data[i] = (i == 0 && sync_first) ? cfg_sync : 8'($urandom);
            crc = crc_byte(crc, data[i]);
        end
        if (!crc_good) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        push_byte(cfg_sync, 1'b1);
        push_byte(addr, 1'b1);
        push_byte(8'(len), 1'b1);
        for (int i = 0; i < len; i++) push_byte(data[i], 1'b1);
        push_byte(crc[7:0], 1'b1);
        push_byte(crc[15:8], 1'b1);
    endtask

    // Hold until every byte has gone and every result has come, then let the
    // run of the last frame settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (tx_bytes.size() != 0 || rx_ch.valid || due_results.size() != 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Feed filler until the receiver is back to hunting; an oversize length
    // closes a frame at once.
    task automatic close_open_frame();
        wait_drained();
        while (fr_phase != HUNT) begin
            push_byte((fr_phase == GET_LEN) ? 8'd255 : 8'($urandom), 1'b1);
            wait_drained();
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_NODE_ADDR:  cfg_node  = val;
            CFG_BCAST_ADDR: cfg_bcast = val;
            default:        cfg_sync  = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] node, input logic [7:0] bcast,
                                 input logic [7:0] sync);
        close_open_frame();
        write_reg(CFG_NODE_ADDR, node);
        write_reg(CFG_BCAST_ADDR, bcast);
        write_reg(CFG_SYNC_VALUE, sync);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return cfg_node;
        if (r < 65) return cfg_bcast;
        return 8'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 4);
        if (r < 90) return $urandom_range(5, MAX_LEN - 1);
        return MAX_LEN;
    endfunction

    // Mostly well-formed frames with random content; the rest is line noise,
    // oversize lengths, cut-off frames and pauses until the receiver drains.
    task automatic run_random(input int target);
        int first;
        int r;
        int cut;
        first = stim_items;
        while (stim_items - first < target) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                add_frame(pick_addr(), pick_len(), $urandom_range(0, 9) != 0,
                          $urandom_range(0, 7) == 0);
            end else if (r < 80) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b1);
            end else if (r < 88) begin
                push_byte(cfg_sync, 1'b1);
                push_byte(pick_addr(), 1'b1);
                push_byte($urandom_range(0, 1) ? 8'(MAX_LEN + 1)
                                               : 8'($urandom_range(MAX_LEN + 1, 255)), 1'b1);
            end else if (r < 95) begin
                cut = $urandom_range(1, 8);
                push_byte(cfg_sync, 1'b1);
                push_byte(pick_addr(), 1'b1);
                push_byte(8'(cut), 1'b1);
                repeat ($urandom_range(0, cut + 1)) push_byte(8'($urandom), 1'b1);
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_NODE_ADDR;
        i_cfg_data     = 8'd0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'd0;
        res_ch.ready   = 1'b0;
        cfg_node       = 8'd0;
        cfg_bcast      = 8'd255;
        cfg_sync       = 8'd126;
        fr_phase       = HUNT;
        fr_addr        = 8'd0;
        fr_len         = 8'd0;
        fr_count       = '0;
        fr_crc         = CRC_SEED;
        fr_crc_lo      = 8'd0;
        err_total      = '0;
        frame_total    = '0;
        mismatch_count = 0;
        stim_items     = 0;
        send_gap       = 0;
        send_busy      = 1'b1;
        stall_left     = 0;
        stall_busy     = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at the reset configuration.
        push_byte(8'h00, 1'b1);                  // idle bytes are dropped
        push_byte(8'hFF, 1'b1);
        add_frame(8'd0, 0, 1'b1, 1'b0);          // empty frame to the node
        push_byte(cfg_sync, 1'b1);               // oversize length closes at once
        push_byte(8'd0, 1'b1);
        push_byte(8'd255, 1'b1);
        add_frame(8'd0, 1, 1'b0, 1'b0);          // corrupted CRC
        add_frame(8'h42, 0, 1'b1, 1'b0);         // someone else's address
        add_frame(8'd255, 1, 1'b1, 1'b1);        // broadcast, sync inside payload

        // Random traffic over several settings, extremes first.
        apply_setting(8'd255, 8'd0, 8'd0);
        run_random(78);
        apply_setting(8'h3C, 8'h3C, 8'd255);     // node address equals broadcast
        run_random(78);
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(78);
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(78);
        apply_setting(8'd1, 8'd255, 8'd126);
        run_random(78);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", 32'(due_results.size()), 32'd0);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
